/* src/tct_pkg.sv */
// shared types and constants of the text console teletype
`default_nettype none
package tct_pkg;

    typedef enum logic [2:0] {
        CMD_TTY    = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_SETCUR = 3'd2,
        CMD_DRAW   = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_CLEAR
    } t_state;

    // control flags from the teletype step to the sequencer
    typedef struct packed {
        logic wr_cell;
        logic need_scroll;
    } t_tty_ctl;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

endpackage
`default_nettype wire

/* src/text_console_teletype_core.sv */
// text console teletype: cell store, cursor and command sequencer
//
// usage: items come in on i_in_valid / o_in_ready with a command and its
// operands; one result item per input item leaves on o_out_valid /
// i_out_ready and carries the cursor, its linear offset, read data and a
// scroll flag. the text color register is written by i_cfg_wr_en with no
// wait; the user must write it only while the block is idle; not enforced.
// timing: teletype bytes without scroll, set cursor and draw complete at
// the accept edge, the result is valid the next cycle, one item per cycle
// while results are taken. a cell read passes through the registered read
// port of the cell memory and then the ST_READ state. a scroll sweeps the
// memory one cell per cycle through its single read and write port, and a
// clear writes one cell per cycle.
// reset: a clearing pass fills every cell with a space and attribute 07
// while o_in_ready stays low.
// stall: a new item is taken only when the output register is empty or is
// being taken in the same cycle; a stalled result holds until taken.
`default_nettype none
module text_console_teletype_core #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [7:0]  i_cell_attr,
    input  wire logic [4:0]  i_pos_row,
    input  wire logic [6:0]  i_pos_col,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_cursor_row,
    output logic [6:0]       o_cursor_col,
    output logic [10:0]      o_cursor_offset,
    output logic [7:0]       o_read_char,
    output logic [7:0]       o_read_attr,
    output logic             o_scrolled
);
    import tct_pkg::*;

    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLS);
    localparam int CELLS     = ROWS * COLS;
    localparam int AW        = $clog2(CELLS);
    localparam int LAST_BASE = (ROWS - 1) * COLS;

    logic [15:0]   r_cell_mem [CELLS];
    logic [15:0]   r_rd_data;

    t_state        r_state, n_state;
    logic [AW-1:0] r_idx;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [7:0]    r_text_color;
    logic          r_wvalid;
    logic [AW-1:0] r_waddr;
    logic          r_wlast;
    logic          r_rd_inside;
    logic          r_out_valid;
    logic [4:0]    r_out_row;
    logic [6:0]    r_out_col;
    logic [10:0]   r_out_offset;
    logic [7:0]    r_out_rchar;
    logic [7:0]    r_out_rattr;
    logic          r_out_scrolled;

    logic          w_in_ready;
    logic          w_accept;
    logic          w_sweep_last;
    logic          w_inside;
    logic [AW-1:0] w_pos_addr;
    logic [AW-1:0] w_cur_addr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic          w_out_load;
    logic [RW-1:0] w_tty_row;
    logic [CW-1:0] w_tty_col;
    t_tty_ctl      w_tty_ctl;

    tct_tty_step #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) u_tty_step (
        .i_row  (r_row),
        .i_col  (r_col),
        .i_char (i_char_code),
        .o_row  (w_tty_row),
        .o_col  (w_tty_col),
        .o_ctl  (w_tty_ctl)
    );

    assign w_in_ready   = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept     = i_in_valid && w_in_ready;
    assign w_sweep_last = (32'(r_idx) == CELLS - 1);
    assign w_inside     = (32'(i_pos_row) < ROWS) && (32'(i_pos_col) < COLS);
    assign w_pos_addr   = AW'(32'(i_pos_row) * COLS + 32'(i_pos_col));
    assign w_cur_addr   = AW'(32'(r_row) * COLS + 32'(r_col));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (w_sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_TTY: begin
                            if (w_tty_ctl.need_scroll) begin
                                n_state = ST_SCROLL;
                            end
                        end
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_READ:  n_state = ST_READ;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:       n_state = ST_IDLE;
            ST_SCROLL: begin
                if (w_sweep_last) begin
                    n_state = ST_SCROLL_END;
                end
            end
            ST_SCROLL_END: n_state = ST_IDLE;
            ST_CLEAR: begin
                if (w_sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_INIT;
        endcase
    end

    // memory port, cursor update and result load
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = {ATTR_RESET, CH_SPACE};
        w_raddr    = w_pos_addr;
        w_out_load = 1'b0;
        n_row      = r_row;
        n_col      = r_col;
        case (r_state)
            ST_INIT: begin
                w_we = 1'b1;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_TTY: begin
                            n_row      = w_tty_row;
                            n_col      = w_tty_col;
                            w_we       = w_tty_ctl.wr_cell;
                            w_waddr    = w_cur_addr;
                            w_wdata    = {r_text_color, i_char_code};
                            w_out_load = !w_tty_ctl.need_scroll;
                        end
                        CMD_CLEAR: begin
                            n_row = '0;
                            n_col = '0;
                        end
                        CMD_SETCUR: begin
                            n_row = (32'(i_pos_row) < ROWS) ? RW'(i_pos_row)
                                                            : RW'(ROWS - 1);
                            n_col = (32'(i_pos_col) < COLS) ? CW'(i_pos_col)
                                                            : CW'(COLS - 1);
                            w_out_load = 1'b1;
                        end
                        CMD_DRAW: begin
                            w_we       = w_inside;
                            w_waddr    = w_pos_addr;
                            w_wdata    = {i_cell_attr, i_char_code};
                            w_out_load = 1'b1;
                        end
                        CMD_READ: begin
                            w_raddr = w_pos_addr;
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                w_out_load = 1'b1;
            end
            ST_SCROLL, ST_SCROLL_END: begin
                // source row is one below; the bottom row reads itself
                w_raddr = (32'(r_idx) < LAST_BASE) ? AW'(32'(r_idx) + COLS) : r_idx;
                w_we    = r_wvalid;
                w_waddr = r_waddr;
                w_wdata = r_wlast ? {r_rd_data[15:8], CH_SPACE} : r_rd_data;
                w_out_load = (r_state == ST_SCROLL_END);
            end
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_wdata    = {r_text_color, CH_SPACE};
                w_out_load = w_sweep_last;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cell_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_cell_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_idx        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_text_color <= ATTR_RESET;
            r_wvalid     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_wvalid <= (r_state == ST_SCROLL);
            if (r_state == ST_INIT || r_state == ST_SCROLL || r_state == ST_CLEAR) begin
                r_idx <= w_sweep_last ? '0 : r_idx + AW'(1);
            end
            if (i_cfg_wr_en) begin
                r_text_color <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= r_idx;
        r_wlast <= (32'(r_idx) >= LAST_BASE);
        if (w_accept) begin
            r_rd_inside <= w_inside;
        end
        if (w_out_load) begin
            r_out_row      <= 5'(n_row);
            r_out_col      <= 7'(n_col);
            r_out_offset   <= 11'(32'(n_row) * COLS + 32'(n_col));
            r_out_rchar    <= (r_state == ST_READ && r_rd_inside) ? r_rd_data[7:0] : 8'h00;
            r_out_rattr    <= (r_state == ST_READ && r_rd_inside) ? r_rd_data[15:8] : 8'h00;
            r_out_scrolled <= (r_state == ST_SCROLL_END);
        end
    end

    assign o_in_ready      = w_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_offset = r_out_offset;
    assign o_read_char     = r_out_rchar;
    assign o_read_attr     = r_out_rattr;
    assign o_scrolled      = r_out_scrolled;

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // the cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLS))
        else $error("cursor off screen");

    // scroll copy never reads the cell it is writing
    a_scroll_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL && r_wvalid) |-> (w_raddr != r_waddr))
        else $error("scroll read overlaps write");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL_END) |-> (32'(r_row) == ROWS - 1) && (r_col == '0))
        else $error("cursor wrong after scroll");

    // sweep counter is parked at zero between sweeps
    a_idx_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_idx == '0))
        else $error("sweep index not cleared");

endmodule
`default_nettype wire

/* src/tct_tty_step.sv */
// cursor movement for one teletype byte
`default_nettype none
module tct_tty_step #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8,
    localparam int RW      = $clog2(ROWS),
    localparam int CW      = $clog2(COLS)
) (
    input  wire logic [RW-1:0] i_row,
    input  wire logic [CW-1:0] i_col,
    input  wire logic [7:0]    i_char,
    output logic [RW-1:0]      o_row,
    output logic [CW-1:0]      o_col,
    output tct_pkg::t_tty_ctl  o_ctl
);
    import tct_pkg::*;

    localparam int NSTOP = COLS / TAB_STOP + 1;
    localparam int TW    = $clog2(NSTOP * TAB_STOP + 1);

    logic [CW:0]   w_col_p1;
    logic [TW-1:0] w_tab;
    logic          w_row_last;
    logic          w_wrap;

    assign w_col_p1   = (CW + 1)'(i_col) + (CW + 1)'(1);
    assign w_row_last = (32'(i_row) == ROWS - 1);

    // smallest tab stop strictly right of the cursor
    always_comb begin
        w_tab = '0;
        for (int k = NSTOP; k >= 1; k--) begin
            if (32'(i_col) < k * TAB_STOP) begin
                w_tab = TW'(k * TAB_STOP);
            end
        end
    end

    always_comb begin
        o_row  = i_row;
        o_col  = i_col;
        o_ctl  = '0;
        w_wrap = 1'b0;
        case (i_char)
            CH_LF: begin
                o_col  = '0;
                w_wrap = 1'b1;
            end
            CH_CR: begin
                o_col = '0;
            end
            CH_BS: begin
                if (i_col != '0) begin
                    o_col = i_col - CW'(1);
                end
            end
            CH_TAB: begin
                if (32'(w_tab) >= COLS) begin
                    o_col  = '0;
                    w_wrap = 1'b1;
                end else begin
                    o_col = CW'(w_tab);
                end
            end
            default: begin
                o_ctl.wr_cell = 1'b1;
                if (32'(w_col_p1) >= COLS) begin
                    o_col  = '0;
                    w_wrap = 1'b1;
                end else begin
                    o_col = CW'(w_col_p1);
                end
            end
        endcase
        if (w_wrap) begin
            if (w_row_last) begin
                o_ctl.need_scroll = 1'b1;
            end else begin
                o_row = i_row + RW'(1);
            end
        end
    end

endmodule
`default_nettype wire
